// File: hdl/rita_pkg.sv
// ----------------------------------------------------------------------------
// rita_pkg: shared types and constants for the radix integer to ASCII block
// Holds the ASCII codes, the radix limits and the per-job control word that
// travels from the classifier to the conversion engine.
// ----------------------------------------------------------------------------
package rita_pkg;

	localparam logic [5:0] BASE_MIN       = 6'd2;
	localparam logic [5:0] BASE_MAX       = 6'd36;
	localparam logic [5:0] DECIMAL_DIGITS = 6'd10;
	localparam logic [7:0] ASCII_ZERO     = 8'd48;
	localparam logic [7:0] ASCII_LETTER   = 8'd55; // 'A' minus ten
	localparam logic [7:0] ASCII_MINUS    = 8'd45;
	localparam int         BITS_PER_STEP  = 8;

	typedef struct packed {
		logic       negative;
		logic [5:0] base;
	} job_ctrl_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] code;
		if (d < DECIMAL_DIGITS) begin
			code = ASCII_ZERO + {2'b00, d};
		end else begin
			code = ASCII_LETTER + {2'b00, d};
		end
		return code;
	endfunction

endpackage

// File: hdl/radix_integer_to_ascii.sv
// One job at a time in the divider, which produces 8 quotient bits per cycle.
// A two-entry queue keeps taking input while the engine works, until it is full.
// Reset: arst_n clears the queue and the engine's control state asynchronously.
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: integer to ASCII digit string in a chosen radix
// Emits one character per transfer, most significant digit first, with a
// leading minus for negative signed values and last set on the final one.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [5:0]             base,
	input  logic                   kind,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             character,
	output logic                   last
);

	logic                   push_valid;
	logic                   push_full;
	rita_pkg::job_ctrl_t    push_ctrl;
	logic [VALUE_WIDTH-1:0] push_mag;
	logic                   pop_valid;
	logic                   pop_stall;
	rita_pkg::job_ctrl_t    pop_ctrl;
	logic [VALUE_WIDTH-1:0] pop_mag;

	rita_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.base       (base),
		.kind       (kind),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_ctrl  (push_ctrl),
		.push_mag   (push_mag)
	);

	rita_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_ctrl  (push_ctrl),
		.push_mag   (push_mag),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_ctrl   (pop_ctrl),
		.pop_mag    (pop_mag)
	);

	rita_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_stall (pop_stall),
		.pop_ctrl  (pop_ctrl),
		.pop_mag   (pop_mag),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

endmodule

// File: hdl/rita_front.sv
// ----------------------------------------------------------------------------
// rita_front: input classifier
// Clamps the radix into range, detects a negative signed value and forms its
// magnitude, then hands the job to the queue.
// ----------------------------------------------------------------------------
module rita_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [5:0]             base,
	input  logic                   kind,
	output logic                   push_valid,
	input  logic                   push_full,
	output rita_pkg::job_ctrl_t    push_ctrl,
	output logic [VALUE_WIDTH-1:0] push_mag
);

	logic negative;

	assign negative   = kind & value[VALUE_WIDTH-1];
	assign push_valid = in_valid;
	assign in_stall   = push_full;

	always_comb begin
		push_ctrl.negative = negative;
		if (base < rita_pkg::BASE_MIN) begin
			push_ctrl.base = rita_pkg::BASE_MIN;
		end else if (base > rita_pkg::BASE_MAX) begin
			push_ctrl.base = rita_pkg::BASE_MAX;
		end else begin
			push_ctrl.base = base;
		end
		// the most negative value negates to itself, which is 2^(W-1) unsigned
		push_mag = negative ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;
	end

endmodule

// File: hdl/rita_queue.sv
// ----------------------------------------------------------------------------
// rita_queue: two-entry job queue
// Decouples the classifier from the conversion engine: jobs wait here until
// the engine takes them, and input is held only when both entries are full.
// ----------------------------------------------------------------------------
module rita_queue #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_full,
	input  rita_pkg::job_ctrl_t    push_ctrl,
	input  logic [VALUE_WIDTH-1:0] push_mag,
	output logic                   pop_valid,
	input  logic                   pop_stall,
	output rita_pkg::job_ctrl_t    pop_ctrl,
	output logic [VALUE_WIDTH-1:0] pop_mag
);

	localparam int ENTRY_W = VALUE_WIDTH + $bits(rita_pkg::job_ctrl_t);

	logic [ENTRY_W-1:0] entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push_xfer;
	logic               pop_xfer;

	assign push_full = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign push_xfer = push_valid && !push_full;
	assign pop_xfer  = pop_valid && !pop_stall;
	assign {pop_ctrl, pop_mag} = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_xfer) begin
			entry_q[wr_ptr_q] <= {push_ctrl, push_mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_xfer) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_xfer) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_xfer, pop_xfer})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/rita_back.sv
// ----------------------------------------------------------------------------
// rita_back: conversion engine
// Divides the magnitude by the radix eight quotient bits per cycle, stores
// the digits least significant first, then sends the sign and the digits
// most significant first.
// ----------------------------------------------------------------------------
module rita_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_stall,
	input  rita_pkg::job_ctrl_t    pop_ctrl,
	input  logic [VALUE_WIDTH-1:0] pop_mag,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             character,
	output logic                   last
);

	localparam int NSTEP = (VALUE_WIDTH + rita_pkg::BITS_PER_STEP - 1) / rita_pkg::BITS_PER_STEP;
	localparam int DW    = NSTEP * rita_pkg::BITS_PER_STEP;
	localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int AW    = $clog2(VALUE_WIDTH);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DIV   = 2'd1;
	localparam logic [1:0] S_FETCH = 2'd2;
	localparam logic [1:0] S_SHOW  = 2'd3;

	logic [1:0]       state_q;
	logic [DW-1:0]    v_q;
	logic [5:0]       base_q;
	logic             neg_q;
	logic [5:0]       rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic [7:0]       digit_mem [VALUE_WIDTH];

	logic [5:0]       rem_nxt;
	logic [6:0]       trial;
	logic [7:0]       qbits;
	logic [DW-1:0]    v_nxt;
	logic             digit_end;
	logic             div_done;
	logic             out_xfer;

	assign pop_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_SHOW);
	assign character = char_q;
	assign last      = last_q;
	assign out_xfer  = out_valid && !out_stall;

	// restoring division, one quotient bit per step
	always_comb begin
		rem_nxt = rem_q;
		trial   = 7'd0;
		qbits   = 8'd0;
		for (int i = 0; i < rita_pkg::BITS_PER_STEP; i++) begin
			trial = {rem_nxt, v_q[DW-1-i]};
			if (trial >= {1'b0, base_q}) begin
				trial    = trial - {1'b0, base_q};
				qbits[7-i] = 1'b1;
			end
			rem_nxt = trial[5:0];
		end
		v_nxt     = (v_q << rita_pkg::BITS_PER_STEP) | DW'(qbits);
		digit_end = (cnt_q == CNT_W'(NSTEP - 1));
		div_done  = digit_end && (v_nxt == '0);
	end

	// digit store and output character register
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && digit_end) begin
			digit_mem[wr_q] <= rita_pkg::digit_char(rem_nxt);
		end
		if (state_q == S_DIV && div_done && neg_q) begin
			char_q <= rita_pkg::ASCII_MINUS;
		end else if (state_q == S_FETCH) begin
			char_q <= digit_mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_q     <= '0;
			base_q  <= rita_pkg::BASE_MIN;
			neg_q   <= 1'b0;
			rem_q   <= 6'd0;
			cnt_q   <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						v_q     <= DW'(pop_mag);
						base_q  <= pop_ctrl.base;
						neg_q   <= pop_ctrl.negative;
						rem_q   <= 6'd0;
						cnt_q   <= '0;
						wr_q    <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					v_q <= v_nxt;
					if (!digit_end) begin
						rem_q <= rem_nxt;
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						rem_q <= 6'd0;
						cnt_q <= '0;
						if (div_done) begin
							rd_q <= wr_q;
							if (neg_q) begin
								last_q  <= 1'b0;
								state_q <= S_SHOW;
							end else begin
								state_q <= S_FETCH;
							end
						end else begin
							wr_q <= wr_q + AW'(1);
						end
					end
				end
				S_FETCH: begin
					last_q  <= (rd_q == '0);
					rd_q    <= rd_q - AW'(1);
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (out_xfer) begin
						state_q <= last_q ? S_IDLE : S_FETCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> base_q >= rita_pkg::BASE_MIN && base_q <= rita_pkg::BASE_MAX)
		else $error("radix out of range during division");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < base_q)
		else $error("partial remainder not below radix");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last_q |=> state_q == S_IDLE)
		else $error("engine busy after final character");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_q == rita_pkg::ASCII_MINUS |-> !last_q)
		else $error("minus sign flagged as final character");
`endif

endmodule
